>>> hw/rtl/swrt_pkg.sv
// Shared types and constants for the sliding window range tracker.
`default_nettype none

package swrt_pkg;

  // Sample and result value width.
  localparam int VAL_W = 31;
  // Width of the window length register.
  localparam int CFG_W = 7;
  // Stream data widths, padded to whole bytes.
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 128;

  typedef logic [VAL_W-1:0] val_t;

  // Per-cycle command to every cell of one queue.
  typedef struct packed {
    logic clear;   // drop all entries (start of a sequence)
    logic shift;   // front entry expired: every cell takes its right neighbor
    logic insert;  // drop dominated entries and append the new sample
  } qctrl_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/swrt_cell.sv
// One cell of a monotonic queue: holds a value, its arrival position and a valid bit.
`default_nettype none

module swrt_cell #(
  parameter int POS_W  = 7,
  parameter bit IS_MAX = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swrt_pkg::qctrl_t    ctrl,
  input  swrt_pkg::val_t      new_val,
  input  logic [POS_W-1:0]    new_pos,
  input  logic                prev_keep,
  input  swrt_pkg::val_t      next_val,
  input  logic [POS_W-1:0]    next_pos,
  input  logic                next_valid,
  output swrt_pkg::val_t      val,
  output logic [POS_W-1:0]    pos,
  output logic                valid,
  output logic                keep
);

  swrt_pkg::val_t   val_r, val_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             valid_r, valid_nxt;
  logic             dominated;
  logic             take;

  // A newer sample dominates this entry when it is at least as good.
  assign dominated = IS_MAX ? (val_r <= new_val) : (val_r >= new_val);
  assign keep      = valid_r & ~dominated;
  // The new sample lands in the first cell that does not keep its entry.
  assign take      = ~keep & prev_keep;

  always_comb begin
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      val_nxt   = next_val;
      pos_nxt   = next_pos;
      valid_nxt = next_valid;
    end else if (ctrl.insert) begin
      if (take) begin
        val_nxt   = new_val;
        pos_nxt   = new_pos;
        valid_nxt = 1'b1;
      end else begin
        valid_nxt = keep;
      end
    end
  end

  // Occupancy bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Entry payload.
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pos_r <= pos_nxt;
  end

  assign val   = val_r;
  assign pos   = pos_r;
  assign valid = valid_r;

endmodule

`default_nettype wire

>>> hw/rtl/swrt_queue.sv
// Monotonic queue built as a chain of cells, oldest entry in the first cell.
`default_nettype none

module swrt_queue #(
  parameter int DEPTH  = 64,
  parameter int POS_W  = 7,
  parameter bit IS_MAX = 1'b1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  swrt_pkg::qctrl_t    ctrl,
  input  swrt_pkg::val_t      new_val,
  input  logic [POS_W-1:0]    now_pos,
  input  logic [POS_W-1:0]    len,
  output logic                front_expired,
  output swrt_pkg::val_t      result
);

  swrt_pkg::val_t   val_a   [DEPTH];
  logic [POS_W-1:0] pos_a   [DEPTH];
  logic             valid_a [DEPTH];
  logic             keep_a  [DEPTH];
  logic [POS_W-1:0] front_age;

  // Cell chain: each cell sees its left neighbor's keep and its right neighbor's entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             prev_keep;
    swrt_pkg::val_t   next_val;
    logic [POS_W-1:0] next_pos;
    logic             next_valid;

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_keep = keep_a[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val   = '0;
      assign next_pos   = '0;
      assign next_valid = 1'b0;
    end else begin : g_link
      assign next_val   = val_a[i+1];
      assign next_pos   = pos_a[i+1];
      assign next_valid = valid_a[i+1];
    end

    swrt_cell #(
      .POS_W  (POS_W),
      .IS_MAX (IS_MAX)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_val    (new_val),
      .new_pos    (now_pos),
      .prev_keep  (prev_keep),
      .next_val   (next_val),
      .next_pos   (next_pos),
      .next_valid (next_valid),
      .val        (val_a[i]),
      .pos        (pos_a[i]),
      .valid      (valid_a[i]),
      .keep       (keep_a[i])
    );
  end

  // Only the oldest entry can leave the window; ages wrap with the position counter.
  assign front_age     = now_pos - pos_a[0];
  assign front_expired = valid_a[0] & (front_age >= len);

  // Queue front after the insert: the surviving oldest entry, or the new sample alone.
  assign result = keep_a[0] ? val_a[0] : new_val;

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_range_tracker.sv
// Top level of the sliding window range tracker.
`default_nettype none

// Reports, for each sample, the maximum and minimum of the last window_length
// samples (current one included), their difference and the largest difference
// since the start of the sequence. Two chains of WINDOW_MAX cells hold the
// max and min monotonic queues. For each item the sequencer retires expired
// queue fronts one per cycle until neither queue has one (when both queues
// have one, they retire it in the same cycle), also after window_length is
// reduced, and then inserts the sample. While the output register still holds
// an unaccepted result, the insert waits for it. A new request is taken while
// the previous result still waits in the output register. A request with
// tuser set clears both queues and the best range before its sample is taken.
// window_length 0 acts as 1, and values above WINDOW_MAX act as WINDOW_MAX.
module sliding_window_range_tracker #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [swrt_pkg::CFG_W-1:0]        cfg_wdata,    // window_length
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swrt_pkg::IN_DATA_W-1:0]    in_tdata,     // [30:0] sample
  input  logic                              in_tuser,     // start_of_sequence
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [30:0] window_max, [61:31] window_min, [92:62] window_range, [123:93] best_range
  output logic [swrt_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int POS_W = $clog2(WINDOW_MAX + 1);
  localparam int PAD_W = swrt_pkg::OUT_DATA_W - 4 * swrt_pkg::VAL_W;

  swrt_pkg::state_t                state_r, state_nxt;
  logic [swrt_pkg::CFG_W-1:0]      cfg_r;
  swrt_pkg::val_t                  sample_r;
  logic [POS_W-1:0]                pos_r;
  swrt_pkg::val_t                  best_r, best_nxt;
  logic                            out_valid_r;
  logic [swrt_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                            in_acc;
  logic                            start;
  logic                            out_free;
  logic                            max_exp, min_exp;
  logic                            insert_go;
  logic [POS_W-1:0]                len_eff;
  swrt_pkg::qctrl_t                max_ctrl, min_ctrl;
  swrt_pkg::val_t                  wmax, wmin, range;

  assign in_tready = (state_r == swrt_pkg::ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign start     = in_acc & in_tuser;
  assign out_free  = ~out_valid_r | out_tready;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    if (cfg_r == '0) begin
      len_eff = POS_W'(1);
    end else if (int'(cfg_r) > WINDOW_MAX) begin
      len_eff = POS_W'(WINDOW_MAX);
    end else begin
      len_eff = POS_W'(cfg_r);
    end
  end

  // Retire expired fronts first; insert once neither queue has one and the output is free.
  assign insert_go = (state_r == swrt_pkg::ST_WORK) & ~max_exp & ~min_exp & out_free;

  always_comb begin
    max_ctrl.clear  = start;
    max_ctrl.shift  = (state_r == swrt_pkg::ST_WORK) & max_exp;
    max_ctrl.insert = insert_go;
    min_ctrl.clear  = start;
    min_ctrl.shift  = (state_r == swrt_pkg::ST_WORK) & min_exp;
    min_ctrl.insert = insert_go;
  end

  swrt_queue #(
    .DEPTH  (WINDOW_MAX),
    .POS_W  (POS_W),
    .IS_MAX (1'b1)
  ) u_max_q (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (max_ctrl),
    .new_val       (sample_r),
    .now_pos       (pos_r),
    .len           (len_eff),
    .front_expired (max_exp),
    .result        (wmax)
  );

  swrt_queue #(
    .DEPTH  (WINDOW_MAX),
    .POS_W  (POS_W),
    .IS_MAX (1'b0)
  ) u_min_q (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (min_ctrl),
    .new_val       (sample_r),
    .now_pos       (pos_r),
    .len           (len_eff),
    .front_expired (min_exp),
    .result        (wmin)
  );

  // Window range and running best.
  assign range    = (wmax >= wmin) ? (wmax - wmin) : '0;
  assign best_nxt = (range > best_r) ? range : best_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swrt_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = swrt_pkg::ST_WORK;
        end
      end
      swrt_pkg::ST_WORK: begin
        if (insert_go) begin
          state_nxt = swrt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swrt_pkg::ST_IDLE;
    endcase
  end

  // Control state, configuration, position counter and best range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swrt_pkg::ST_IDLE;
      cfg_r       <= swrt_pkg::CFG_W'(1);
      pos_r       <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (start) begin
        best_r <= '0;
      end else if (insert_go) begin
        best_r <= best_nxt;
      end
      if (insert_go) begin
        pos_r       <= pos_r + POS_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample capture and result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_tdata[swrt_pkg::VAL_W-1:0];
    end
    if (insert_go) begin
      out_data_r <= {{PAD_W{1'b0}}, best_nxt, range, wmin, wmax};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> hw/rtl/swrt_checker.sv
// Port-level checks for the sliding window range tracker, bound to the top level.
`default_nettype none

module swrt_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [swrt_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The window maximum never falls below the window minimum.
  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:0] >= out_tdata[61:31])
    else $error("window max below window min");

  // The reported range is the difference of the reported extremes.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[92:62] == out_tdata[30:0] - out_tdata[61:31])
    else $error("window range does not match max minus min");

  // The best range covers the current range.
  a_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[123:93] >= out_tdata[92:62])
    else $error("best range below current range");

endmodule

bind sliding_window_range_tracker swrt_checker u_swrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
